// File: design/ppvs_pkg.sv
// Package for the probabilistic partition victim select unit.
// Holds sizes, codes and shared types; depends on nothing.
package ppvs_pkg;
    localparam int WAYS = 16;
    localparam int CORES = 4;
    localparam int SETS = 64;
    localparam int WAY_W = 4;
    localparam int CORE_W = 2;
    localparam int OWN_W = 3;
    localparam int SET_W = 6;
    localparam int PROB_W = 15;
    localparam int CNT_W = 11;
    localparam int CLS_W = 3;
    localparam int AGE_W = 4;
    localparam logic [PROB_W-1:0] PROB_ONE = 15'd32767;
    localparam logic [PROB_W-1:0] PROB_RESET = 15'd8192;
    localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;
    localparam logic [OWN_W-1:0] NO_OWNER = 3'd4;
    localparam logic [CLS_W-1:0] CLS_MUST = 3'd0;
    localparam logic [CLS_W-1:0] CLS_TGT = 3'd1;
    localparam logic [CLS_W-1:0] CLS_OTH = 3'd2;
    localparam logic [CLS_W-1:0] CLS_LRU = 3'd3;
    localparam logic [CLS_W-1:0] CLS_HIT = 3'd4;

    typedef logic [WAYS*AGE_W-1:0] age_row_t;
    typedef logic [WAYS*OWN_W-1:0] own_row_t;

    // running scan result passed from the scanner to the top
    typedef struct packed {
        logic             one_ok;
        logic             tgt_ok;
        logic             oth_ok;
        logic [AGE_W-1:0] one_age;
        logic [AGE_W-1:0] tgt_age;
        logic [AGE_W-1:0] oth_age;
        logic [WAY_W-1:0] one_pos;
        logic [WAY_W-1:0] tgt_pos;
        logic [WAY_W-1:0] oth_pos;
        logic [WAY_W-1:0] lru_pos;
    } scan_t;
endpackage

// File: design/ppvs_scan_step.sv
// Shared compare unit: folds one way into the running victim candidates.
// Depends on ppvs_pkg.
module ppvs_scan_step (
    input  ppvs_pkg::scan_t                cur,
    input  logic [ppvs_pkg::WAY_W-1:0]     way,
    input  logic [ppvs_pkg::AGE_W-1:0]     age,
    input  logic [ppvs_pkg::OWN_W-1:0]     owner,
    input  logic [ppvs_pkg::OWN_W-1:0]     target,
    input  logic [ppvs_pkg::CORES*ppvs_pkg::PROB_W-1:0] probs,
    output ppvs_pkg::scan_t                nxt
);
    import ppvs_pkg::*;
    logic owned;
    logic [PROB_W-1:0] p;
    logic must;
    logic can;

    always_comb
    begin
        owned = owner < OWN_W'(CORES);
        p = probs[owner[CORE_W-1:0]*PROB_W +: PROB_W];
        must = owned && (p == PROB_ONE);
        can = !owned || (p != '0);
        nxt = cur;
        if (must && cur.one_age <= age)
        begin
            nxt.one_age = age;
            nxt.one_pos = way;
            nxt.one_ok = 1'b1;
        end
        else if (owned && owner == target && cur.tgt_age <= age)
        begin
            nxt.tgt_age = age;
            nxt.tgt_pos = way;
            nxt.tgt_ok = 1'b1;
        end
        else if (cur.oth_age <= age && can)
        begin
            nxt.oth_age = age;
            nxt.oth_pos = way;
            nxt.oth_ok = 1'b1;
        end
        if (age == AGE_W'(WAYS-1))
            nxt.lru_pos = way;
    end
endmodule

// File: design/probabilistic_partition_victim_select_unit.sv
// Sequence: a hit goes through read, update, write-back and then the done strobe;
// a miss goes through read with target draw, WAYS scan steps through the shared compare
// unit, update, write-back and then the done strobe.
// A new request is taken in the strobe cycle, so one request is handled at a time.
// busy stays high for the whole request; the receiver cannot stall.
// Reset: a clearing pass rewrites every set row; busy is high during it.
module probabilistic_partition_victim_select_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [ppvs_pkg::PROB_W-1:0]      cfg_data,
    input  logic                             mode,
    input  logic [ppvs_pkg::SET_W-1:0]       set_addr,
    input  logic [ppvs_pkg::WAY_W-1:0]       hit_way,
    input  logic [ppvs_pkg::CORE_W-1:0]      requesting_core,
    input  logic [ppvs_pkg::PROB_W-1:0]      random_draw,
    output logic                             done,
    output logic [ppvs_pkg::WAY_W-1:0]       chosen_way,
    output logic [ppvs_pkg::CLS_W-1:0]       victim_class,
    output logic [ppvs_pkg::OWN_W-1:0]       drawn_core,
    output logic [ppvs_pkg::OWN_W-1:0]       previous_owner,
    output logic [ppvs_pkg::CNT_W-1:0]       core_occupancy
);
    import ppvs_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // set rows: ages and owners of all ways, one wide word each
    age_row_t age_mem [SETS];
    own_row_t own_mem [SETS];
    age_row_t age_rd_reg;
    own_row_t own_rd_reg;

    logic [CORES*PROB_W-1:0] prob_reg;
    logic [CNT_W-1:0] cnt_reg [CORES];

    logic [SET_W-1:0] clr_reg;
    logic [SET_W-1:0] set_reg;
    logic mode_reg;
    logic [WAY_W-1:0] hway_reg;
    logic [CORE_W-1:0] req_reg;
    logic [PROB_W-1:0] draw_reg;
    logic [OWN_W-1:0] tgt_reg;
    logic tgt_found_reg;
    logic [WAY_W:0] step_reg;
    scan_t scan_reg, scan_nxt;
    logic [WAY_W-1:0] vic_reg;
    logic [CLS_W-1:0] cls_reg;
    age_row_t age_wb_reg;
    own_row_t own_wb_reg;

    logic [WAY_W-1:0] cur_way;

    // reset contents of one set row: way i holds age i, no owner
    age_row_t age_init;
    own_row_t own_init;

    assign busy = (state_reg != ST_IDLE);
    assign cur_way = step_reg[WAY_W-1:0];

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            age_init[i*AGE_W +: AGE_W] = AGE_W'(i);
            own_init[i*OWN_W +: OWN_W] = NO_OWNER;
        end
    end

    ppvs_scan_step u_step (
        .cur    (scan_reg),
        .way    (cur_way),
        .age    (age_rd_reg[cur_way*AGE_W +: AGE_W]),
        .owner  (own_rd_reg[cur_way*OWN_W +: OWN_W]),
        .target (tgt_reg),
        .probs  (prob_reg),
        .nxt    (scan_nxt)
    );

    // victim choice and make-newest on the row
    logic [WAY_W-1:0] vic_sel;
    logic [CLS_W-1:0] cls_sel;
    age_row_t age_new;
    own_row_t own_new;
    logic [AGE_W-1:0] a_old;

    always_comb
    begin
        if (!mode_reg)
        begin
            vic_sel = hway_reg;
            cls_sel = CLS_HIT;
        end
        else if (scan_reg.one_ok)
        begin
            vic_sel = scan_reg.one_pos;
            cls_sel = CLS_MUST;
        end
        else if (scan_reg.tgt_ok)
        begin
            vic_sel = scan_reg.tgt_pos;
            cls_sel = CLS_TGT;
        end
        else if (scan_reg.oth_ok)
        begin
            vic_sel = scan_reg.oth_pos;
            cls_sel = CLS_OTH;
        end
        else
        begin
            vic_sel = scan_reg.lru_pos;
            cls_sel = CLS_LRU;
        end
        a_old = age_rd_reg[vic_sel*AGE_W +: AGE_W];
        for (int i = 0; i < WAYS; i++)
        begin
            if (age_rd_reg[i*AGE_W +: AGE_W] < a_old)
                age_new[i*AGE_W +: AGE_W] = age_rd_reg[i*AGE_W +: AGE_W] + AGE_W'(1);
            else
                age_new[i*AGE_W +: AGE_W] = age_rd_reg[i*AGE_W +: AGE_W];
        end
        age_new[vic_sel*AGE_W +: AGE_W] = '0;
        // a fill hands the victim line to the requester
        own_new = own_rd_reg;
        if (mode_reg)
            own_new[vic_sel*OWN_W +: OWN_W] = {1'b0, req_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == SET_W'(SETS-1)) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = ST_READ;
            ST_READ:  state_next = mode_reg ? ST_SCAN : ST_UPD;
            ST_SCAN:  if (step_reg == (WAY_W+1)'(WAYS-1)) state_next = ST_UPD;
            ST_UPD:   state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            done <= 1'b0;
            for (int c = 0; c < CORES; c++)
            begin
                prob_reg[c*PROB_W +: PROB_W] <= PROB_RESET;
                cnt_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done <= 1'b0;
            if (cfg_we)
                prob_reg[cfg_index*PROB_W +: PROB_W] <= cfg_data;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + SET_W'(1);
            if (state_reg == ST_UPD && mode_reg)
            begin
                // drop a line from the old owner, add one to the requester
                logic [OWN_W-1:0] pv;
                pv = own_rd_reg[vic_sel*OWN_W +: OWN_W];
                for (int c = 0; c < CORES; c++)
                begin
                    logic [CNT_W-1:0] v;
                    v = cnt_reg[c];
                    if (pv == OWN_W'(c) && v != '0)
                        v = v - CNT_W'(1);
                    if (req_reg == CORE_W'(c) && v != COUNT_MAX)
                        v = v + CNT_W'(1);
                    cnt_reg[c] <= v;
                end
            end
            if (state_reg == ST_WRITE)
                done <= 1'b1;
        end
    end

    // set row storage and datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            age_mem[clr_reg] <= age_init;
            own_mem[clr_reg] <= own_init;
        end
        if (state_reg == ST_IDLE && start)
        begin
            set_reg <= set_addr;
            mode_reg <= mode;
            hway_reg <= hit_way;
            req_reg <= requesting_core;
            draw_reg <= random_draw;
        end
        age_rd_reg <= age_mem[set_reg];
        own_rd_reg <= own_mem[set_reg];
        if (state_reg == ST_READ)
        begin
            step_reg <= '0;
            scan_reg <= '0;
        end
        if (state_reg == ST_SCAN)
        begin
            step_reg <= step_reg + (WAY_W+1)'(1);
            scan_reg <= scan_nxt;
        end
        // resolve the target core in the read cycle, so it is ready before the
        // first scan step compares owners against it
        if (state_reg == ST_READ)
        begin : drawblk
            logic [PROB_W-1:0] r;
            logic [OWN_W-1:0] t;
            r = draw_reg;
            t = NO_OWNER;
            for (int c = 0; c < CORES; c++)
            begin
                if (t == NO_OWNER)
                begin
                    if (r < prob_reg[c*PROB_W +: PROB_W])
                        t = OWN_W'(c);
                    else if (prob_reg[c*PROB_W +: PROB_W] != PROB_ONE)
                        r = r - prob_reg[c*PROB_W +: PROB_W];
                end
            end
            tgt_reg <= t;
            tgt_found_reg <= (t != NO_OWNER);
        end
        if (state_reg == ST_UPD)
        begin
            vic_reg <= vic_sel;
            cls_reg <= cls_sel;
            age_wb_reg <= age_new;
            own_wb_reg <= own_new;
            previous_owner <= mode_reg ? own_rd_reg[vic_sel*OWN_W +: OWN_W] : NO_OWNER;
            drawn_core <= mode_reg ? tgt_reg : NO_OWNER;
        end
        if (state_reg == ST_WRITE)
        begin
            age_mem[set_reg] <= age_wb_reg;
            own_mem[set_reg] <= own_wb_reg;
            chosen_way <= vic_reg;
            victim_class <= cls_reg;
            core_occupancy <= cnt_reg[req_reg];
        end
    end

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_WRITE)) else $error("done without write-back");
    a_tgt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> (tgt_found_reg == (tgt_reg != NO_OWNER)))
        else $error("target flag mismatch");
endmodule
